// ----- sv/min_cost_context_length_search_defines.svh -----
// Assertion macros used by the search controller module.
`ifndef MIN_COST_CONTEXT_LENGTH_SEARCH_DEFINES_SVH
`define MIN_COST_CONTEXT_LENGTH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MCCLS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MCCLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/mccls_pkg.sv -----
// Types and constants of the context length search block.
package mccls_pkg;

   localparam int LEN_W = 10;

   localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
   localparam logic [1:0] REQ_LOAD_MATCH  = 2'd2;
   localparam logic [1:0] REQ_COMPUTE     = 2'd3;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [LEN_W-1:0] value_a;
      logic [LEN_W-1:0] value_b;
   } req_item_type;

   typedef struct packed {
      logic             found;
      logic [LEN_W-1:0] first_length;
      logic [LEN_W-1:0] second_length;
      logic             overflow;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic init;
      logic rnd_wr;
      logic f_lat;
      logic m_use;
      logic s_use;
      logic eval;
      logic finish;
   } ctl_cmd_type;

endpackage

// ----- sv/mccls_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mccls_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/mccls_dp.sv -----
// Datapath: boundary lists, match and candidate stores, search registers.
module mccls_dp import mccls_pkg::*; #(
   parameter int MAX_BOUNDS  = 32,
   parameter int MAX_MATCHES = 256,
   parameter int MAX_LENGTH  = 1023
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ctl_cmd_type                          cmd,
   input  logic [$clog2(MAX_MATCHES+1)-1:0]     idx_i,
   input  logic [$clog2(MAX_MATCHES+1)-1:0]     idx_j,
   input  req_item_type                         req_data,
   output logic [$clog2(MAX_MATCHES+1)-1:0]     match_count,
   output rsp_item_type                         rsp_data
);

   localparam int CW  = $clog2(MAX_MATCHES+1);
   localparam int MAW = MAX_MATCHES > 1 ? $clog2(MAX_MATCHES) : 1;
   localparam int BW  = $clog2(MAX_BOUNDS+1);
   localparam int IW  = MAX_BOUNDS > 1 ? $clog2(MAX_BOUNDS) : 1;
   localparam logic [16:0] MAXL = 17'(MAX_LENGTH);

   logic [LEN_W-1:0] first_bounds_ff  [MAX_BOUNDS];
   logic [LEN_W-1:0] second_bounds_ff [MAX_BOUNDS];
   logic [LEN_W-1:0] first_last_ff, second_last_ff;
   logic [BW-1:0]    first_count_ff, second_count_ff;
   logic [CW-1:0]    match_count_ff;
   logic             overflow_ff;

   logic [LEN_W-1:0] sat_a, sat_b;
   logic             match_we;
   logic [2*LEN_W-1:0] match_rdata;
   logic [LEN_W-1:0] m_a, m_b;
   logic [LEN_W-1:0] rnd_a, rnd_b;
   logic             cand_we;
   logic [CW-1:0]    cand_waddr;
   logic [LEN_W-1:0] cand_f_wdata, cand_s_wdata;
   logic [LEN_W-1:0] fc_rdata, sc_rdata;

   logic [LEN_W-1:0] f_ff, maxb_ff, smin_ff;
   logic             any_ff, sfound_ff;
   logic             found_ff;
   logic [LEN_W-1:0] best_f_ff, best_s_ff;
   rsp_item_type     rsp_ff;

   logic [LEN_W:0]   cand_sum, best_sum;
   logic             better;
   logic             s_ok;

   assign sat_a = ({7'd0, req_data.value_a} > MAXL) ? MAXL[LEN_W-1:0] : req_data.value_a;
   assign sat_b = ({7'd0, req_data.value_b} > MAXL) ? MAXL[LEN_W-1:0] : req_data.value_b;

   assign match_we = cmd.load && (req_data.req_type == REQ_LOAD_MATCH)
                     && (match_count_ff != CW'(MAX_MATCHES));

   mccls_ram #(.WIDTH(2*LEN_W), .DEPTH(MAX_MATCHES)) u_match_ram (
      .clock (clock),
      .we    (match_we),
      .waddr (match_count_ff[MAW-1:0]),
      .wdata ({sat_a, sat_b}),
      .raddr (idx_j[MAW-1:0]),
      .rdata (match_rdata)
   );

   assign m_a = match_rdata[2*LEN_W-1:LEN_W];
   assign m_b = match_rdata[LEN_W-1:0];

   // First boundary above the length in load order, else the last one loaded, or zero if none.
   always_comb begin
      rnd_a = (first_count_ff != '0) ? first_last_ff : '0;
      for (int k = MAX_BOUNDS-1; k >= 0; k--) begin
         if ((BW'(k) < first_count_ff) && (first_bounds_ff[k] > m_a)) begin
            rnd_a = first_bounds_ff[k];
         end
      end
   end

   always_comb begin
      rnd_b = (second_count_ff != '0) ? second_last_ff : '0;
      for (int k = MAX_BOUNDS-1; k >= 0; k--) begin
         if ((BW'(k) < second_count_ff) && (second_bounds_ff[k] > m_b)) begin
            rnd_b = second_bounds_ff[k];
         end
      end
   end

   assign cand_we      = cmd.init || cmd.rnd_wr;
   assign cand_waddr   = cmd.init ? '0 : idx_j + CW'(1);
   assign cand_f_wdata = cmd.init ? '0 : rnd_a;
   assign cand_s_wdata = cmd.init ? '0 : rnd_b;

   mccls_ram #(.WIDTH(LEN_W), .DEPTH(MAX_MATCHES+1)) u_fc_ram (
      .clock (clock),
      .we    (cand_we),
      .waddr (cand_waddr),
      .wdata (cand_f_wdata),
      .raddr (idx_i),
      .rdata (fc_rdata)
   );

   mccls_ram #(.WIDTH(LEN_W), .DEPTH(MAX_MATCHES+1)) u_sc_ram (
      .clock (clock),
      .we    (cand_we),
      .waddr (cand_waddr),
      .wdata (cand_s_wdata),
      .raddr (idx_j),
      .rdata (sc_rdata)
   );

   // A second length clears every match that covers f only if above their max.
   assign s_ok = !any_ff || (sc_rdata > maxb_ff);

   assign cand_sum = {1'b0, f_ff} + {1'b0, smin_ff};
   assign best_sum = {1'b0, best_f_ff} + {1'b0, best_s_ff};
   assign better   = !found_ff || (cand_sum < best_sum) ||
                     ((cand_sum == best_sum) &&
                      ((f_ff < best_f_ff) || ((f_ff == best_f_ff) && (smin_ff < best_s_ff))));

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         match_count_ff  <= '0;
         overflow_ff     <= 1'b0;
      end else if (cmd.finish) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         match_count_ff  <= '0;
         overflow_ff     <= 1'b0;
      end else if (cmd.load) begin
         case (req_data.req_type)
            REQ_LOAD_FIRST: begin
               if (first_count_ff != BW'(MAX_BOUNDS)) begin
                  first_count_ff <= first_count_ff + BW'(1);
               end else begin
                  overflow_ff <= 1'b1;
               end
            end
            REQ_LOAD_SECOND: begin
               if (second_count_ff != BW'(MAX_BOUNDS)) begin
                  second_count_ff <= second_count_ff + BW'(1);
               end else begin
                  overflow_ff <= 1'b1;
               end
            end
            REQ_LOAD_MATCH: begin
               if (match_count_ff != CW'(MAX_MATCHES)) begin
                  match_count_ff <= match_count_ff + CW'(1);
               end else begin
                  overflow_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (req_data.req_type == REQ_LOAD_FIRST)
          && (first_count_ff != BW'(MAX_BOUNDS))) begin
         first_bounds_ff[first_count_ff[IW-1:0]] <= sat_a;
         first_last_ff <= sat_a;
      end
      if (cmd.load && (req_data.req_type == REQ_LOAD_SECOND)
          && (second_count_ff != BW'(MAX_BOUNDS))) begin
         second_bounds_ff[second_count_ff[IW-1:0]] <= sat_a;
         second_last_ff <= sat_a;
      end
      if (cmd.init) begin
         found_ff  <= 1'b0;
         best_f_ff <= '0;
         best_s_ff <= '0;
      end
      if (cmd.f_lat) begin
         f_ff      <= fc_rdata;
         any_ff    <= 1'b0;
         maxb_ff   <= '0;
         sfound_ff <= 1'b0;
         smin_ff   <= '0;
      end
      if (cmd.m_use && (m_a >= f_ff)) begin
         any_ff <= 1'b1;
         if (!any_ff || (m_b > maxb_ff)) begin
            maxb_ff <= m_b;
         end
      end
      if (cmd.s_use && s_ok && (!sfound_ff || (sc_rdata < smin_ff))) begin
         sfound_ff <= 1'b1;
         smin_ff   <= sc_rdata;
      end
      if (cmd.eval && sfound_ff && better) begin
         found_ff  <= 1'b1;
         best_f_ff <= f_ff;
         best_s_ff <= smin_ff;
      end
      if (cmd.finish) begin
         rsp_ff.found         <= found_ff;
         rsp_ff.first_length  <= best_f_ff;
         rsp_ff.second_length <= best_s_ff;
         rsp_ff.overflow      <= overflow_ff;
      end
   end

   assign match_count = match_count_ff;
   assign rsp_data    = rsp_ff;

endmodule

// ----- sv/mccls_ctrl.sv -----
// Controller: item acceptance and the sequencing of the search.
module mccls_ctrl import mccls_pkg::*; #(
   parameter int MAX_MATCHES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [1:0]                       req_type,
   input  logic [$clog2(MAX_MATCHES+1)-1:0] match_count,
   output logic                             busy,
   output logic                             rsp_valid,
   output ctl_cmd_type                      cmd,
   output logic [$clog2(MAX_MATCHES+1)-1:0] idx_i,
   output logic [$clog2(MAX_MATCHES+1)-1:0] idx_j
);

`include "min_cost_context_length_search_defines.svh"

   localparam int CW = $clog2(MAX_MATCHES+1);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_R_RD, S_R_WR, S_F_RD, S_F_LAT,
      S_M_RD, S_M_USE, S_S_RD, S_S_USE, S_EVAL, S_DONE
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic          rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start && (req_type == REQ_COMPUTE)) begin
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               i_ff     <= '0;
               j_ff     <= '0;
               state_ff <= (match_count == '0) ? S_F_RD : S_R_RD;
            end
            S_R_RD:  state_ff <= S_R_WR;
            S_R_WR: begin
               if ((j_ff + CW'(1)) == match_count) begin
                  j_ff     <= '0;
                  state_ff <= S_F_RD;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_R_RD;
               end
            end
            S_F_RD:  state_ff <= S_F_LAT;
            S_F_LAT: begin
               j_ff     <= '0;
               state_ff <= (match_count == '0) ? S_S_RD : S_M_RD;
            end
            S_M_RD:  state_ff <= S_M_USE;
            S_M_USE: begin
               if ((j_ff + CW'(1)) == match_count) begin
                  j_ff     <= '0;
                  state_ff <= S_S_RD;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_M_RD;
               end
            end
            S_S_RD:  state_ff <= S_S_USE;
            S_S_USE: begin
               // candidate lists hold match_count + 1 entries
               if (j_ff == match_count) begin
                  state_ff <= S_EVAL;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_S_RD;
               end
            end
            S_EVAL: begin
               if (i_ff == match_count) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_F_RD;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == S_IDLE) && start && (req_type != REQ_COMPUTE);
      cmd.init   = (state_ff == S_INIT);
      cmd.rnd_wr = (state_ff == S_R_WR);
      cmd.f_lat  = (state_ff == S_F_LAT);
      cmd.m_use  = (state_ff == S_M_USE);
      cmd.s_use  = (state_ff == S_S_USE);
      cmd.eval   = (state_ff == S_EVAL);
      cmd.finish = (state_ff == S_DONE);
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign idx_i     = i_ff;
   assign idx_j     = j_ff;

   `MCCLS_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `MCCLS_ASSERT_NOW(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `MCCLS_ASSERT_NEXT(a_compute_busy, clock, reset,
      start && !busy && (req_type == REQ_COMPUTE), busy)

endmodule

// ----- sv/min_cost_context_length_search.sv -----
// Load items never produce a result; busy stays low. A compute item holds
// busy high while the controller builds the candidate lists and then walks,
// for each first candidate, over the match and candidate RAMs.
// Its result strobes on rsp_valid for one cycle right after busy falls.
// Synchronous reset clears all counts and the overflow flag.
module min_cost_context_length_search import mccls_pkg::*; #(
   parameter int MAX_BOUNDS  = 32,
   parameter int MAX_MATCHES = 256,
   parameter int MAX_LENGTH  = 1023
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   localparam int CW = $clog2(MAX_MATCHES+1);

   ctl_cmd_type   cmd;
   logic [CW-1:0] idx_i, idx_j, match_count;

   mccls_ctrl #(.MAX_MATCHES(MAX_MATCHES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_type    (req_data.req_type),
      .match_count (match_count),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .cmd         (cmd),
      .idx_i       (idx_i),
      .idx_j       (idx_j)
   );

   mccls_dp #(
      .MAX_BOUNDS  (MAX_BOUNDS),
      .MAX_MATCHES (MAX_MATCHES),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .idx_i       (idx_i),
      .idx_j       (idx_j),
      .req_data    (req_data),
      .match_count (match_count),
      .rsp_data    (rsp_data)
   );

endmodule
